FILE: sv/timeout_frame_receiver_xor_check_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the timeout frame receiver
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef TIMEOUT_FRAME_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH
`define TIMEOUT_FRAME_RECEIVER_XOR_CHECK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge outside reset.
`define TFRX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tfrx assertion failed");

// Property checked on every clock edge, reset included.
`define TFRX_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tfrx assertion failed");

`else

`define TFRX_ASSERT(lbl, clk, rst_n, prop)
`define TFRX_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: sv/tfrx_pkg.sv
// ---------------------------------------------------------------------------
// tfrx_pkg
// Shared types, codes and frame constants of the timeout frame receiver.
// ---------------------------------------------------------------------------
package tfrx_pkg;

    localparam int BYTE_W      = 8;
    localparam int FLEN_W      = 6;
    localparam int MAX_RESULTS = 64;
    localparam int HDR_LEN     = 3;

    localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h6D;
    localparam logic [BYTE_W-1:0] SUM_ZERO  = 8'hFF;

    typedef enum logic [0:0] {
        CFG_IDLE_TIMEOUT = 1'b0,
        CFG_CHECK_MODE   = 1'b1
    } t_cfg_idx;

    typedef enum logic [0:0] {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        STAT_VALID   = 3'd0,
        STAT_BAD_HDR = 3'd1,
        STAT_BAD_TRL = 3'd2,
        STAT_BAD_SUM = 3'd3,
        STAT_RAW     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_CHK,
        KIND_DATA
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_CHK,
        ST_CHK_WAIT,
        ST_DECIDE,
        ST_DATA,
        ST_DRAIN
    } t_state;

    // Tag that travels with a buffer read until its data returns.
    typedef struct packed {
        logic  vld;
        t_kind kind;
        logic  last;
    } t_tag;

    // Verdict of the frame check walk.
    typedef struct packed {
        logic hdr_bad;
        logic trl_bad;
        logic sum_bad;
    } t_chk_flags;

    // Expected header character at a header position.
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] c;
        unique case (pos)
            2'd0:    c = CH_L;
            2'd1:    c = CH_D;
            2'd2:    c = CH_N;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/tfrx_ram.sv
// ---------------------------------------------------------------------------
// tfrx_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module tfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tfrx_eval.sv
// ---------------------------------------------------------------------------
// tfrx_eval
// Frame check datapath: header, XOR group sums and trailer, one byte a cycle.
// ---------------------------------------------------------------------------
`include "timeout_frame_receiver_xor_check_core_defines.svh"

module tfrx_eval
    import tfrx_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int GROUP_COUNT  = 4,
    parameter int GROUP_BYTES  = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clear,
    input  logic                            i_vld,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] i_addr,
    input  logic [BYTE_W-1:0]               i_data,
    output t_chk_flags                      o_flags
);

    localparam int AW         = $clog2(BUFFER_DEPTH);
    localparam int GW         = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int CW         = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
    localparam int SUM_BASE   = HDR_LEN + GROUP_COUNT * GROUP_BYTES;
    localparam int TRAIL_BASE = SUM_BASE + GROUP_COUNT;

    logic [BYTE_W-1:0] r_sums [GROUP_COUNT];
    logic [GW-1:0]     r_grp;
    logic [CW-1:0]     r_gcnt;
    t_chk_flags        r_flags;

    logic [GW-1:0]     grp_next;
    logic [BYTE_W-1:0] sum_fixed;
    logic              in_hdr;
    logic              in_data;
    logic              in_sums;

    assign grp_next  = (r_grp == GW'(GROUP_COUNT - 1)) ? '0 : r_grp + 1'b1;
    // A group sum of zero goes on the wire as all ones.
    assign sum_fixed = (r_sums[r_grp] == '0) ? SUM_ZERO : r_sums[r_grp];
    assign in_hdr    = i_addr < AW'(HDR_LEN);
    assign in_data   = !in_hdr && (i_addr < AW'(SUM_BASE));
    assign in_sums   = !in_hdr && !in_data && (i_addr < AW'(TRAIL_BASE));

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            for (int g = 0; g < GROUP_COUNT; g++) begin
                r_sums[g] <= '0;
            end
        end else if (i_vld && in_data) begin
            r_sums[r_grp] <= r_sums[r_grp] ^ i_data;
        end else if (i_vld && in_sums) begin
            r_sums[r_grp] <= sum_fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp   <= '0;
            r_gcnt  <= '0;
            r_flags <= '0;
        end else if (i_clear) begin
            r_grp   <= '0;
            r_gcnt  <= '0;
            r_flags <= '0;
        end else if (i_vld) begin
            priority if (in_hdr) begin
                if (i_data != hdr_char(i_addr[1:0])) begin
                    r_flags.hdr_bad <= 1'b1;
                end
            end else if (in_data) begin
                if (r_gcnt == CW'(GROUP_BYTES - 1)) begin
                    r_gcnt <= '0;
                    r_grp  <= grp_next;
                end else begin
                    r_gcnt <= r_gcnt + 1'b1;
                end
            end else if (in_sums) begin
                if (sum_fixed != i_data) begin
                    r_flags.sum_bad <= 1'b1;
                end
                r_grp <= grp_next;
            end else if (i_addr == AW'(TRAIL_BASE)) begin
                if (i_data != CH_A) begin
                    r_flags.trl_bad <= 1'b1;
                end
            end else if (i_addr == AW'(TRAIL_BASE + 1)) begin
                if (i_data != CH_M) begin
                    r_flags.trl_bad <= 1'b1;
                end
            end else begin
                r_flags <= r_flags;
            end
        end
    end

    assign o_flags = r_flags;

    `TFRX_ASSERT(a_grp_in_range, i_clk, i_rst_n, r_grp <= GW'(GROUP_COUNT - 1))
    `TFRX_ASSERT(a_clear_flags, i_clk, i_rst_n, i_clear |=> (r_flags == '0))

endmodule

FILE: sv/timeout_frame_receiver_xor_check_core.sv
// ---------------------------------------------------------------------------
// timeout_frame_receiver_xor_check_core
// Idle-timeout frame receiver with header, trailer and XOR group check.
// ---------------------------------------------------------------------------
// Usage:
// An item is taken when start is high and busy is low. With i_req_type at
// zero it is a received byte, stored in the frame buffer; with it at one it
// is a timer tick. Bytes and ticks that do not end a frame produce no
// result, so busy stays low.
// The tick that runs the idle counter down to zero ends the frame. Busy
// then rises while a sequencer walks the buffer RAM, one read a cycle,
// through its registered read port. A raw frame of n bytes gives
// min(n,63) results at the default depth, on consecutive cycles. A checked
// frame first walks the header, data, sum and trailer positions
// (TRAIL_BASE + 2 reads, 49 by default) and decides in ST_DECIDE after a
// ST_CHK_WAIT state: a failed frame gives its single status result as busy
// falls. A good frame then walks the data bytes again (40 by default).
// Each result is shown for one cycle on o_strobe; the receiver cannot stall.
// Configuration writes are always ready outside reset and are meant to be
// made while busy is low. Reset empties the buffer at once through per-entry
// valid bits, so no clearing pass is needed; the same bits clear the buffer
// after a good frame.
// ---------------------------------------------------------------------------
`include "timeout_frame_receiver_xor_check_core_defines.svh"

module timeout_frame_receiver_xor_check_core
    import tfrx_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int GROUP_COUNT  = 4,
    parameter int GROUP_BYTES  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item channel.
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // Configuration write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    // Result channel.
    output logic              o_strobe,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [2:0]        o_status,
    output logic [FLEN_W-1:0] o_frame_length,
    output logic              o_last
);

    localparam int AW         = $clog2(BUFFER_DEPTH);
    localparam int SUM_BASE   = HDR_LEN + GROUP_COUNT * GROUP_BYTES;
    localparam int TRAIL_BASE = SUM_BASE + GROUP_COUNT;

    // Sequencer control decoded from the state.
    typedef struct packed {
        logic  issue;
        t_kind kind;
        logic  at_end;
        logic  clear_valid;
        logic  fail;
    } t_ctrl;

    // Configuration registers.
    logic [BYTE_W-1:0] r_timeout;
    logic              r_check_mode;

    // Receive side state.
    logic [AW-1:0]           r_wi;
    logic [BYTE_W-1:0]       r_idle;
    logic [BUFFER_DEPTH-1:0] r_valid;

    // Walk sequencer.
    t_state        r_state;
    t_state        n_state;
    t_ctrl         ctrl;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_len;

    // Read return stage.
    t_tag          r_ret;
    logic [AW-1:0] r_ret_addr;
    logic          r_rd_vld;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] ret_byte;

    // Result registers.
    logic              r_strobe;
    logic [BYTE_W-1:0] r_out_byte;
    t_status           r_status;
    logic              r_last;
    logic              n_strobe;
    logic [BYTE_W-1:0] n_out_byte;
    t_status           n_status;
    logic              n_last;

    t_chk_flags flags;
    t_status    fail_code;

    logic          accept;
    logic          is_byte;
    logic          frame_end;
    logic          ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic [AW:0]   len_ext;
    logic [AW-1:0] raw_end;

    assign busy        = (r_state != ST_IDLE) || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign accept      = start && !busy;
    assign is_byte     = (i_req_type == REQ_BYTE);

    // The tick that takes the counter from one to zero closes the frame; an
    // empty frame closes without results and without touching the buffer.
    assign frame_end = accept && !is_byte && (r_idle == 8'd1) && (r_wi != '0);

    // Bytes and the zero terminator share the single write port at r_wi.
    // The walk only starts after that write, so busy is the interlock
    // between the write side and the reads of the walk.
    assign ram_we    = (accept && is_byte) || frame_end;
    assign ram_wdata = is_byte ? i_rx_byte : '0;

    // Raw frames report at most MAX_RESULTS bytes.
    assign len_ext = {1'b0, r_wi};
    assign raw_end = (len_ext > (AW + 1)'(MAX_RESULTS)) ? AW'(MAX_RESULTS - 1)
                                                        : r_wi - 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= 8'd10;
            r_check_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IDLE_TIMEOUT: r_timeout    <= i_cfg_data;
                CFG_CHECK_MODE:   r_check_mode <= i_cfg_data[0];
                default:          r_timeout    <= r_timeout;
            endcase
        end
    end

    // Write index, idle counter and buffer valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi    <= '0;
            r_idle  <= '0;
            r_valid <= '0;
        end else begin
            if (accept && is_byte) begin
                r_valid[r_wi] <= 1'b1;
                // The index parks on the last entry once the buffer is full.
                if (r_wi != AW'(BUFFER_DEPTH - 1)) begin
                    r_wi <= r_wi + 1'b1;
                end
                r_idle <= r_timeout;
            end else if (accept && (r_idle != '0)) begin
                r_idle <= r_idle - 1'b1;
                if (r_idle == 8'd1) begin
                    r_wi <= '0;
                end
                if (frame_end) begin
                    r_valid[r_wi] <= 1'b1;
                end
            end
            // A good frame empties the whole buffer at once.
            if (ctrl.clear_valid) begin
                r_valid <= '0;
            end
        end
    end

    tfrx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wi),
        .i_wdata (ram_wdata),
        .i_re    (ctrl.issue),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Next state of the walk sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (frame_end) begin
                    n_state = r_check_mode ? ST_CHK : ST_RAW;
                end
            end
            ST_RAW: begin
                if (r_addr == r_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_CHK: begin
                if (r_addr == r_end) begin
                    n_state = ST_CHK_WAIT;
                end
            end
            ST_CHK_WAIT: n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_state = (flags != '0) ? ST_IDLE : ST_DATA;
            end
            ST_DATA: begin
                if (r_addr == r_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the walk sequencer.
    always_comb begin
        ctrl = '0;
        ctrl.kind   = KIND_RAW;
        ctrl.at_end = (r_addr == r_end);
        unique case (r_state)
            ST_RAW: begin
                ctrl.issue = 1'b1;
                ctrl.kind  = KIND_RAW;
            end
            ST_CHK: begin
                ctrl.issue = 1'b1;
                ctrl.kind  = KIND_CHK;
            end
            ST_DATA: begin
                ctrl.issue       = 1'b1;
                ctrl.kind        = KIND_DATA;
                ctrl.clear_valid = ctrl.at_end;
            end
            ST_DECIDE: ctrl.fail = (flags != '0);
            default:   ctrl.issue = 1'b0;
        endcase
    end

    // Sequencer registers and read return stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret.vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret.vld <= ctrl.issue;
        end
        r_ret.kind <= ctrl.kind;
        r_ret.last <= ctrl.at_end;
        r_ret_addr <= r_addr;
        r_rd_vld   <= r_valid[r_addr];
        if (frame_end) begin
            r_len  <= r_wi;
            r_addr <= '0;
            r_end  <= r_check_mode ? AW'(TRAIL_BASE + 1) : raw_end;
        end else if (r_state == ST_DECIDE) begin
            // The second walk covers only the data bytes.
            r_addr <= AW'(HDR_LEN);
            r_end  <= AW'(SUM_BASE - 1);
        end else if (ctrl.issue) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // Entries never written since reset or since the last clear read as zero.
    assign ret_byte = r_rd_vld ? ram_q : '0;

    tfrx_eval #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .GROUP_COUNT  (GROUP_COUNT),
        .GROUP_BYTES  (GROUP_BYTES)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (frame_end),
        .i_vld   (r_ret.vld && (r_ret.kind == KIND_CHK)),
        .i_addr  (r_ret_addr),
        .i_data  (ret_byte),
        .o_flags (flags)
    );

    // Header failures win over trailer failures, which win over sums.
    always_comb begin
        priority if (flags.hdr_bad) begin
            fail_code = STAT_BAD_HDR;
        end else if (flags.trl_bad) begin
            fail_code = STAT_BAD_TRL;
        end else begin
            fail_code = STAT_BAD_SUM;
        end
    end

    // Result selection: streamed buffer bytes or the single status item.
    always_comb begin
        n_strobe   = ctrl.fail || (r_ret.vld && (r_ret.kind != KIND_CHK));
        n_out_byte = ctrl.fail ? '0 : ret_byte;
        n_last     = ctrl.fail || r_ret.last;
        if (ctrl.fail) begin
            n_status = fail_code;
        end else if (r_ret.kind == KIND_RAW) begin
            n_status = STAT_RAW;
        end else begin
            n_status = STAT_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_out_byte <= n_out_byte;
        r_status   <= n_status;
        r_last     <= n_last;
    end

    assign o_strobe       = r_strobe;
    assign o_out_byte     = r_out_byte;
    assign o_status       = r_status;
    assign o_frame_length = r_len[FLEN_W-1:0];
    assign o_last         = r_last;

    `TFRX_ASSERT(a_last_then_quiet, i_clk, i_rst_n, (r_strobe && r_last) |=> !r_strobe)
    `TFRX_ASSERT(a_more_while_busy, i_clk, i_rst_n, (r_strobe && !r_last) |-> busy)
    `TFRX_ASSERT(a_decide_drained, i_clk, i_rst_n, (r_state == ST_DECIDE) |-> !r_ret.vld)
    `TFRX_ASSERT(a_clear_empties, i_clk, i_rst_n, ctrl.clear_valid |=> (r_valid == '0))

endmodule
